// ===== hdl/rmstep_pkg.sv =====
// ----------------------------------------------------------------------------
// rmstep_pkg
// Shared types, opcodes and register codes for the six-register step unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rmstep_pkg;

  localparam int NumRegs  = 6;
  localparam int WordW    = 64;
  localparam int RidxW    = 3;
  localparam int OpW      = 4;
  localparam int OperandW = 16;
  localparam int StartW   = 8;
  localparam int LenW     = 9;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 9;
  localparam int HalfW    = WordW / 2;

  typedef logic [WordW-1:0] word_t;
  typedef logic [RidxW-1:0] ridx_t;

  // opcodes
  localparam logic [OpW-1:0] OP_ADDR = 4'd0;
  localparam logic [OpW-1:0] OP_ADDI = 4'd1;
  localparam logic [OpW-1:0] OP_MULR = 4'd2;
  localparam logic [OpW-1:0] OP_MULI = 4'd3;
  localparam logic [OpW-1:0] OP_BANR = 4'd4;
  localparam logic [OpW-1:0] OP_BANI = 4'd5;
  localparam logic [OpW-1:0] OP_BORR = 4'd6;
  localparam logic [OpW-1:0] OP_BORI = 4'd7;
  localparam logic [OpW-1:0] OP_SETR = 4'd8;
  localparam logic [OpW-1:0] OP_SETI = 4'd9;
  localparam logic [OpW-1:0] OP_GTIR = 4'd10;
  localparam logic [OpW-1:0] OP_GTRI = 4'd11;
  localparam logic [OpW-1:0] OP_GTRR = 4'd12;
  localparam logic [OpW-1:0] OP_EQIR = 4'd13;
  localparam logic [OpW-1:0] OP_EQRI = 4'd14;
  localparam logic [OpW-1:0] OP_EQRR = 4'd15;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_PTR_REG  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_START    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PROG_LEN = 2'd2;

  // configuration reset values
  localparam logic [RidxW-1:0]  RST_PTR_REG  = 3'd3;
  localparam logic [StartW-1:0] RST_START    = 8'd1;
  localparam logic [LenW-1:0]   RST_PROG_LEN = 9'd36;

  typedef struct packed {
    logic a_is_reg;
    logic b_is_reg;
    logic bad;
    logic is_mul;
  } decode_t;

  typedef struct packed {
    logic  en;
    logic  wen;
    ridx_t dest;
  } commit_t;

endpackage

`default_nettype wire

// ===== hdl/rmstep_mul.sv =====
// ----------------------------------------------------------------------------
// rmstep_mul
// Low 64 bits of a 64x64 product over three passes of one 32x32 multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module rmstep_mul
  import rmstep_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  clear,
  input  word_t a,
  input  word_t b,
  output logic  done,
  output word_t prod
);

  localparam logic [1:0] CntLoLo = 2'd0;
  localparam logic [1:0] CntLoHi = 2'd1;
  localparam logic [1:0] CntHiLo = 2'd2;
  localparam logic [1:0] CntDone = 2'd3;

  logic [1:0]       cnt;
  logic [HalfW-1:0] m_x;
  logic [HalfW-1:0] m_y;
  logic [WordW-1:0] m_p;
  word_t            p_low;
  logic [HalfW-1:0] cross_sum;

  always_comb begin
    unique case (cnt)
      CntLoHi: begin
        m_x = a[HalfW-1:0];
        m_y = b[WordW-1:HalfW];
      end
      CntHiLo: begin
        m_x = a[WordW-1:HalfW];
        m_y = b[HalfW-1:0];
      end
      default: begin
        m_x = a[HalfW-1:0];
        m_y = b[HalfW-1:0];
      end
    endcase
  end

  assign m_p = m_x * m_y;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      cnt <= CntLoLo;
    end else if (start && cnt != CntDone) begin
      cnt <= cnt + 2'd1;
    end
  end

  // cross terms only reach the upper half, so their low 32 bits suffice
  always_ff @(posedge clk) begin
    if (start) begin
      case (cnt)
        CntLoLo: p_low <= m_p;
        CntLoHi: cross_sum <= m_p[HalfW-1:0];
        CntHiLo: cross_sum <= cross_sum + m_p[HalfW-1:0];
        default: ;
      endcase
    end
  end

  assign done = start && cnt == CntDone;
  assign prod = {p_low[WordW-1:HalfW] + cross_sum, p_low[HalfW-1:0]};

  a_cnt_needs_start: assert property (@(posedge clk) disable iff (rst)
    cnt != CntLoLo |-> start)
    else $error("multiplier advanced without a multiply item");

endmodule

`default_nettype wire

// ===== hdl/rmstep_regs.sv =====
// ----------------------------------------------------------------------------
// rmstep_regs
// Register file and pointer: run start, pointer binding, reads and commit.
// ----------------------------------------------------------------------------
`default_nettype none

module rmstep_regs
  import rmstep_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              first,
  input  ridx_t             ptr_sel,
  input  logic [StartW-1:0] start_value,
  input  ridx_t             rd_a,
  input  ridx_t             rd_b,
  input  commit_t           cmt,
  input  word_t             res,
  output word_t             va_reg,
  output word_t             vb_reg,
  output word_t             next_ptr,
  output word_t             reg0_after
);

  word_t reg_file [NumRegs];
  word_t ptr;
  word_t ptr_base;
  word_t pre  [NumRegs];
  word_t post [NumRegs];
  logic  bound;

  assign ptr_base = first ? '0 : ptr;
  assign bound    = ptr_sel < RidxW'(NumRegs);

  // state as the instruction sees it: run start, then pointer into its register
  always_comb begin
    for (int i = 0; i < NumRegs; i++) begin
      if (ptr_sel == RidxW'(i)) begin
        pre[i] = ptr_base;
      end else if (first) begin
        pre[i] = (i == 0) ? WordW'(start_value) : '0;
      end else begin
        pre[i] = reg_file[i];
      end
      post[i] = (cmt.wen && cmt.dest == RidxW'(i)) ? res : pre[i];
    end
  end

  assign va_reg = (rd_a < RidxW'(NumRegs)) ? pre[rd_a] : '0;
  assign vb_reg = (rd_b < RidxW'(NumRegs)) ? pre[rd_b] : '0;

  // the bound register holds ptr_base unless this instruction overwrote it
  assign next_ptr   = (bound && cmt.wen && cmt.dest == ptr_sel) ? res + 64'd1
                                                                : ptr_base + 64'd1;
  assign reg0_after = post[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumRegs; i++) begin
        reg_file[i] <= '0;
      end
      ptr <= '0;
    end else if (cmt.en) begin
      for (int i = 0; i < NumRegs; i++) begin
        reg_file[i] <= post[i];
      end
      ptr <= next_ptr;
    end
  end

  a_first_ptr: assert property (@(posedge clk) disable iff (rst)
    cmt.en && first && !(cmt.wen && cmt.dest == ptr_sel) |=> ptr == 64'd1)
    else $error("run start did not leave pointer at one");

  a_bound_ptr: assert property (@(posedge clk) disable iff (rst)
    cmt.en && bound |=> ptr == reg_file[$past(ptr_sel)] + 64'd1)
    else $error("pointer out of step with its bound register");

endmodule

`default_nettype wire

// ===== hdl/rmstep_alu.sv =====
// ----------------------------------------------------------------------------
// rmstep_alu
// Opcode decode, index check, operand selection and result for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module rmstep_alu
  import rmstep_pkg::*;
(
  input  logic [OpW-1:0]      command,
  input  logic [OperandW-1:0] operand_a,
  input  logic [OperandW-1:0] operand_b,
  input  ridx_t               dest_index,
  input  word_t               va_reg,
  input  word_t               vb_reg,
  input  word_t               mul_prod,
  output decode_t             dec,
  output word_t               va,
  output word_t               vb,
  output word_t               res
);

  always_comb begin
    unique case (command) inside
      OP_SETR: begin
        dec.a_is_reg = 1'b1;
        dec.b_is_reg = 1'b0;
      end
      OP_SETI: begin
        dec.a_is_reg = 1'b0;
        dec.b_is_reg = 1'b0;
      end
      OP_GTIR, OP_EQIR: begin
        dec.a_is_reg = 1'b0;
        dec.b_is_reg = 1'b1;
      end
      OP_GTRI, OP_EQRI: begin
        dec.a_is_reg = 1'b1;
        dec.b_is_reg = 1'b0;
      end
      OP_GTRR, OP_EQRR: begin
        dec.a_is_reg = 1'b1;
        dec.b_is_reg = 1'b1;
      end
      // arithmetic and logic: even codes take b from a register
      default: begin
        dec.a_is_reg = 1'b1;
        dec.b_is_reg = ~command[0];
      end
    endcase
    dec.bad = dest_index >= RidxW'(NumRegs)
           || (dec.a_is_reg && operand_a >= OperandW'(NumRegs))
           || (dec.b_is_reg && operand_b >= OperandW'(NumRegs));
    dec.is_mul = command == OP_MULR || command == OP_MULI;
  end

  assign va = dec.a_is_reg ? va_reg : WordW'(operand_a);
  assign vb = dec.b_is_reg ? vb_reg : WordW'(operand_b);

  always_comb begin
    unique case (command) inside
      OP_ADDR, OP_ADDI:          res = va + vb;
      OP_MULR, OP_MULI:          res = mul_prod;
      OP_BANR, OP_BANI:          res = va & vb;
      OP_BORR, OP_BORI:          res = va | vb;
      OP_SETR, OP_SETI:          res = va;
      OP_GTIR, OP_GTRI, OP_GTRR: res = WordW'($signed(va) > $signed(vb));
      default:                   res = WordW'(va == vb);
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/register_machine_step_unit.sv =====
// ----------------------------------------------------------------------------
// register_machine_step_unit
// Six-register machine, one instruction per item, pointer bound to a register.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  input     in_valid / in_ready       command, operand_a, operand_b,
//                                      dest_index, first
//  output    out_valid / out_ready     next_pointer, reg_zero, halted, bad_index
//  config    cfg_valid / cfg_ready     cfg_index, cfg_data (always ready)
//
//  one item per cycle while the output is free and no multiply is running;
//  an item lands in the input register, executes from there and its result
//  is registered. a multiply item holds the input register while one shared
//  32x32 multiplier runs three passes, and the next item waits behind it.
//  reset clears the registers, the pointer and the valids and loads the
//  configuration defaults. a stalled output holds the item in the input
//  register; a new item is taken only while it is empty or being emptied.
// ----------------------------------------------------------------------------
`default_nettype none

module register_machine_step_unit
  import rmstep_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [OpW-1:0]             command,
  input  logic [OperandW-1:0]        operand_a,
  input  logic [OperandW-1:0]        operand_b,
  input  logic [RidxW-1:0]           dest_index,
  input  logic                       first,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [WordW-1:0]    next_pointer,
  output logic signed [WordW-1:0]    reg_zero,
  output logic                       halted,
  output logic                       bad_index,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CfgIdxW-1:0]         cfg_index,
  input  logic [CfgDataW-1:0]        cfg_data
);

  // configuration
  ridx_t             ptr_sel;
  logic [StartW-1:0] start_value;
  logic [LenW-1:0]   program_length;

  // input register
  logic                item_valid;
  logic [OpW-1:0]      item_command;
  logic [OperandW-1:0] item_a;
  logic [OperandW-1:0] item_b;
  ridx_t               item_dest;
  logic                item_first;

  decode_t dec;
  commit_t cmt;
  word_t   va_reg;
  word_t   vb_reg;
  word_t   va;
  word_t   vb;
  word_t   res;
  word_t   mul_prod;
  word_t   next_ptr;
  word_t   reg0_after;
  logic    mul_start;
  logic    mul_done;
  logic    out_free;
  logic    fire;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr_sel        <= RST_PTR_REG;
      start_value    <= RST_START;
      program_length <= RST_PROG_LEN;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PTR_REG:  ptr_sel        <= cfg_data[RidxW-1:0];
        CFG_START:    start_value    <= cfg_data[StartW-1:0];
        CFG_PROG_LEN: program_length <= cfg_data[LenW-1:0];
        default: ;
      endcase
    end
  end

  assign mul_start = item_valid && dec.is_mul && !dec.bad;
  assign out_free  = !out_valid || out_ready;
  assign fire      = item_valid && out_free && (!mul_start || mul_done);
  assign in_ready  = !item_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_command <= command;
      item_a       <= operand_a;
      item_b       <= operand_b;
      item_dest    <= dest_index;
      item_first   <= first;
    end
  end

  rmstep_alu u_alu (
    .command    (item_command),
    .operand_a  (item_a),
    .operand_b  (item_b),
    .dest_index (item_dest),
    .va_reg     (va_reg),
    .vb_reg     (vb_reg),
    .mul_prod   (mul_prod),
    .dec        (dec),
    .va         (va),
    .vb         (vb),
    .res        (res)
  );

  rmstep_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .clear (fire),
    .a     (va),
    .b     (vb),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign cmt.en   = fire;
  assign cmt.wen  = !dec.bad;
  assign cmt.dest = item_dest;

  rmstep_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .first       (item_first),
    .ptr_sel     (ptr_sel),
    .start_value (start_value),
    .rd_a        (item_a[RidxW-1:0]),
    .rd_b        (item_b[RidxW-1:0]),
    .cmt         (cmt),
    .res         (res),
    .va_reg      (va_reg),
    .vb_reg      (vb_reg),
    .next_ptr    (next_ptr),
    .reg0_after  (reg0_after)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      next_pointer <= next_ptr;
      reg_zero     <= reg0_after;
      // negative or past the program
      halted       <= (|next_ptr[WordW-1:LenW]) || (next_ptr[LenW-1:0] >= program_length);
      bad_index    <= dec.bad;
    end
  end

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> item_valid)
    else $error("accepted item missing from input register");

  a_fire_shows: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("executed item has no result");

  a_mul_waits: assert property (@(posedge clk) disable iff (rst)
    item_valid && mul_start && !mul_done |=> item_valid && $stable(item_command))
    else $error("multiply item left before its product was ready");

endmodule

`default_nettype wire

// ===== tb/tb_register_machine_step_unit.sv =====
// ----------------------------------------------------------------------------
// tb_register_machine_step_unit
// Self-checking bench for the six-register step unit. A directed table walks
// every opcode, bad register indexes and pointer jumps, then random programs
// run under several pointer bindings, start values and program lengths. Each
// accepted item is run through a local machine model and each result is
// compared field by field, in order, against it or a typed-in expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_register_machine_step_unit;
  import rmstep_pkg::*;

  localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;
  localparam int NumDir   = 27;
  localparam int NumPhase = 9;
  localparam int PhaseLen = 160;

  typedef struct packed {
    logic [OpW-1:0]      op;
    logic [OperandW-1:0] a;
    logic [OperandW-1:0] b;
    ridx_t               dest;
    logic                first;
  } instr_t;

  typedef struct packed {
    word_t nxt;
    word_t r0;
    logic  halt;
    logic  bad;
  } step_t;

  typedef struct packed {
    instr_t ins;
    logic   pinned;
    step_t  res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OpW-1:0] command = '0;
  logic [OperandW-1:0] operand_a = '0;
  logic [OperandW-1:0] operand_b = '0;
  logic [RidxW-1:0] dest_index = '0;
  logic first = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [WordW-1:0] next_pointer;
  logic signed [WordW-1:0] reg_zero;
  logic halted;
  logic bad_index;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // typed-in expectation travelling with the item
  logic  pin_en = 1'b0;
  step_t pin_res = '0;

  int src_idle = 32;
  int snk_idle = 81;
  int mismatches = 0;

  // machine model state
  word_t            mach_regs [NumRegs];
  word_t            mach_ip;
  logic [RidxW-1:0] bind_sel;
  logic [StartW-1:0] start_val;
  logic [LenW-1:0]  prog_len;
  step_t            pending_steps [$];

  dir_row_t dir_rows [NumDir];

  int unsigned phase_bind  [NumPhase] = '{0, 5, 7, 2, 1, 6, 4, 3, 0};
  int unsigned phase_start [NumPhase] = '{0, 255, 17, 128, 1, 255, 0, 200, 255};
  int unsigned phase_len   [NumPhase] = '{1, 256, 36, 0, 511, 100, 8, 256, 64};

  register_machine_step_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .operand_a(operand_a), .operand_b(operand_b),
    .dest_index(dest_index), .first(first),
    .out_valid(out_valid), .out_ready(out_ready),
    .next_pointer(next_pointer), .reg_zero(reg_zero),
    .halted(halted), .bad_index(bad_index),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // executes one instruction on the model and returns the reported step
  function automatic step_t exec_step(instr_t ins);
    step_t r;
    logic  a_reg, b_reg, bad, bound;
    word_t va, vb, val, nxt;
    va = '0;
    vb = '0;
    val = '0;
    if (ins.first) begin
      for (int i = 0; i < NumRegs; i++) mach_regs[i] = '0;
      mach_regs[0] = word_t'(start_val);
      mach_ip = '0;
    end
    bound = bind_sel < NumRegs;
    if (bound) mach_regs[bind_sel] = mach_ip;
    case (ins.op)
      OP_SETR: begin a_reg = 1'b1; b_reg = 1'b0; end
      OP_SETI: begin a_reg = 1'b0; b_reg = 1'b0; end
      OP_GTIR, OP_EQIR: begin a_reg = 1'b0; b_reg = 1'b1; end
      OP_GTRI, OP_EQRI: begin a_reg = 1'b1; b_reg = 1'b0; end
      OP_GTRR, OP_EQRR: begin a_reg = 1'b1; b_reg = 1'b1; end
      default: begin a_reg = 1'b1; b_reg = ~ins.op[0]; end
    endcase
    bad = ins.dest >= NumRegs || (a_reg && ins.a >= NumRegs) || (b_reg && ins.b >= NumRegs);
    if (!bad) begin
      va = a_reg ? mach_regs[ins.a[2:0]] : word_t'(ins.a);
      vb = b_reg ? mach_regs[ins.b[2:0]] : word_t'(ins.b);
      case (ins.op)
        OP_ADDR, OP_ADDI: val = va + vb;
        OP_MULR, OP_MULI: val = va * vb;
        OP_BANR, OP_BANI: val = va & vb;
        OP_BORR, OP_BORI: val = va | vb;
        OP_SETR, OP_SETI: val = va;
        OP_GTIR, OP_GTRI, OP_GTRR: val = ($signed(va) > $signed(vb)) ? 64'd1 : 64'd0;
        default: val = (va == vb) ? 64'd1 : 64'd0;
      endcase
      mach_regs[ins.dest] = val;
    end
    nxt = bound ? mach_regs[bind_sel] + 64'd1 : mach_ip + 64'd1;
    mach_ip = nxt;
    r.nxt = nxt;
    r.r0 = mach_regs[0];
    r.halt = nxt[WordW-1] || nxt >= word_t'(prog_len);
    r.bad = bad;
    return r;
  endfunction

  // mostly legal register indexes, now and then out of range or a wide immediate
  function automatic logic [OperandW-1:0] pick_operand();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 90) return OperandW'($urandom_range(0, NumRegs - 1));
    if (r < 94) return OperandW'($urandom_range(NumRegs, 7));
    return OperandW'($urandom_range(0, 65535));
  endfunction

  function automatic instr_t rand_instr();
    instr_t ins;
    ins.op = OpW'($urandom_range(0, 15));
    ins.a = pick_operand();
    ins.b = pick_operand();
    ins.dest = ($urandom_range(0, 99) < 95) ? RidxW'($urandom_range(0, NumRegs - 1))
                                            : RidxW'($urandom_range(NumRegs, 7));
    ins.first = $urandom_range(0, 99) < 4;
    return ins;
  endfunction

  always @(posedge clk) begin : monitor
    step_t want;
    if (rst) begin
      for (int i = 0; i < NumRegs; i++) mach_regs[i] = '0;
      mach_ip = '0;
      bind_sel = RST_PTR_REG;
      start_val = RST_START;
      prog_len = RST_PROG_LEN;
      pending_steps.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PTR_REG:  bind_sel = cfg_data[RidxW-1:0];
          CFG_START:    start_val = cfg_data[StartW-1:0];
          CFG_PROG_LEN: prog_len = cfg_data[LenW-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (pending_steps.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: next=%0d r0=%0d halt=%0b bad=%0b",
                     next_pointer, reg_zero, halted, bad_index);
          mismatches++;
        end else begin
          want = pending_steps.pop_front();
          if (next_pointer !== want.nxt || reg_zero !== want.r0 ||
              halted !== want.halt || bad_index !== want.bad) begin
            if (mismatches < 10)
              $display("mismatch: exp next=%0d r0=%0d halt=%0b bad=%0b, got next=%0d r0=%0d halt=%0b bad=%0b",
                       $signed(want.nxt), $signed(want.r0), want.halt, want.bad,
                       next_pointer, reg_zero, halted, bad_index);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        want = exec_step({command, operand_a, operand_b, dest_index, first});
        pending_steps.push_back(pin_en ? pin_res : want);
      end
    end
  end

  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= snk_idle);

  // call at a clock edge; returns at the edge where the item is taken
  task automatic send_item(input instr_t ins, input logic pinned, input step_t res);
    int gap = 0;
    while ($urandom_range(0, 99) < src_idle && gap < 40) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= ins.op;
    operand_a <= ins.a;
    operand_b <= ins.b;
    dest_index <= ins.dest;
    first <= ins.first;
    pin_en <= pinned;
    pin_res <= res;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // wait for all results, then let the pipeline settle
  task automatic drain();
    while (pending_steps.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin : stimulus
    dir_rows = '{
      // straight after reset: pointer bound to r3, start 1, length 36
      '{'{OP_ADDI, 16'd0, 16'd0, 3'd1, 1'b0}, 1'b1, '{64'd1, 64'd0, 1'b0, 1'b0}},
      '{'{OP_SETI, 16'hFFFF, 16'hFFFF, 3'd0, 1'b1}, 1'b1, '{64'd1, 64'd65535, 1'b0, 1'b0}},
      '{'{OP_MULI, 16'd0, 16'hFFFF, 3'd0, 1'b0}, 1'b0, '0},
      '{'{OP_MULR, 16'd0, 16'd0, 3'd1, 1'b0}, 1'b0, '0},
      '{'{OP_ADDR, 16'd1, 16'd0, 3'd2, 1'b0}, 1'b0, '0},
      '{'{OP_BANR, 16'd2, 16'd1, 3'd4, 1'b0}, 1'b0, '0},
      '{'{OP_BANI, 16'd0, 16'h00FF, 3'd5, 1'b0}, 1'b0, '0},
      '{'{OP_BORR, 16'd4, 16'd5, 3'd1, 1'b0}, 1'b0, '0},
      '{'{OP_BORI, 16'd1, 16'h8000, 3'd2, 1'b0}, 1'b0, '0},
      '{'{OP_SETR, 16'd2, 16'hFFFF, 3'd4, 1'b0}, 1'b0, '0},
      '{'{OP_GTIR, 16'hFFFF, 16'd1, 3'd5, 1'b0}, 1'b0, '0},
      '{'{OP_GTRI, 16'd1, 16'hFFFF, 3'd5, 1'b0}, 1'b0, '0},
      '{'{OP_GTRR, 16'd2, 16'd4, 3'd0, 1'b0}, 1'b0, '0},
      '{'{OP_EQIR, 16'd0, 16'd0, 3'd1, 1'b0}, 1'b0, '0},
      '{'{OP_EQRI, 16'd5, 16'd1, 3'd2, 1'b0}, 1'b0, '0},
      '{'{OP_EQRR, 16'd4, 16'd2, 3'd0, 1'b0}, 1'b0, '0},
      // bad indexes skip the write but the pointer still moves
      '{'{OP_ADDR, 16'd7, 16'd7, 3'd7, 1'b1}, 1'b1, '{64'd1, 64'd1, 1'b0, 1'b1}},
      '{'{OP_EQRR, 16'd0, 16'd6, 3'd2, 1'b0}, 1'b1, '{64'd2, 64'd1, 1'b0, 1'b1}},
      '{'{OP_GTIR, 16'hFFFF, 16'd5, 3'd6, 1'b0}, 1'b1, '{64'd3, 64'd1, 1'b0, 1'b1}},
      // setr never checks operand b
      '{'{OP_SETR, 16'd0, 16'hFFFF, 3'd5, 1'b0}, 1'b1, '{64'd4, 64'd1, 1'b0, 1'b0}},
      // jump past the program, then keep executing from there
      '{'{OP_SETI, 16'hFFFF, 16'd0, 3'd3, 1'b0}, 1'b1, '{64'd65536, 64'd1, 1'b1, 1'b0}},
      '{'{OP_ADDI, 16'd3, 16'd0, 3'd0, 1'b0}, 1'b1, '{64'd65537, 64'd65536, 1'b1, 1'b0}},
      // build 2^63 and load it into the pointer register
      '{'{OP_SETI, 16'h8000, 16'd0, 3'd1, 1'b0}, 1'b0, '0},
      '{'{OP_MULR, 16'd1, 16'd1, 3'd1, 1'b0}, 1'b0, '0},
      '{'{OP_MULR, 16'd1, 16'd1, 3'd1, 1'b0}, 1'b0, '0},
      '{'{OP_MULI, 16'd1, 16'd8, 3'd3, 1'b0}, 1'b0, '0},
      '{'{OP_GTIR, 16'hFFFF, 16'd3, 3'd2, 1'b0}, 1'b0, '0}
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) send_item(dir_rows[i].ins, dir_rows[i].pinned, dir_rows[i].res);
    in_valid <= 1'b0;
    drain();

    for (int ph = 0; ph < NumPhase; ph++) begin
      if (ph == 3) begin
        src_idle = 81;
        snk_idle = 32;
      end else if (ph == 6) begin
        src_idle = 0;
        snk_idle = 0;
      end
      write_cfg(CFG_PTR_REG, CfgDataW'(phase_bind[ph]));
      write_cfg(CFG_START, CfgDataW'(phase_start[ph]));
      write_cfg(CFG_PROG_LEN, CfgDataW'(phase_len[ph]));
      // the spare index must not disturb anything
      if (ph == 4) write_cfg(CFG_SPARE, CfgDataW'($urandom_range(0, 511)));
      cfg_valid <= 1'b0;
      for (int n = 0; n < PhaseLen; n++) send_item(rand_instr(), 1'b0, '0);
      in_valid <= 1'b0;
      drain();
    end

    if (mismatches == 0) begin
      $display("tb_register_machine_step_unit OK");
    end else begin
      $display("tb_register_machine_step_unit NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("tb_register_machine_step_unit NOT OK");
    $finish;
  end

endmodule
